// ===== design/pol_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants for the positional ordered list
// Operation and status codes, widths, the front-to-back command struct and the engine states.
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int DEPTH   = 64;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int POS_W   = 8;
    localparam int WHERE_W = 7;
    localparam int QDEPTH  = 2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BOUNDS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
        logic [POS_W-1:0] position;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DECIDE,
        BK_HOLD,
        BK_SHIFT_RD,
        BK_SHIFT_WR,
        BK_SCAN,
        BK_SCAN_CHK,
        BK_EMIT
    } bk_state_t;

endpackage
`default_nettype wire

// ===== design/positional_ordered_list_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_ordered_list_top: ordered list of signed 32-bit values
// Insert, delete, search and readout over a list held in one RAM.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat per command (op, value, position), taken into a
// two-entry queue, so the sender is stalled only when the queue is full.
// Result channel m_*: one beat for insert, delete and search; one beat per
// stored entry for readout of a non-empty list, with m_last on the final beat of each command.
// Work: a decision step, then insert and delete move each shifted entry with
// one RAM read and one RAM write, search visits one entry per cycle, and
// readout reads one entry per beat; the pace is set by the single read and
// write port of the entry RAM.
// Reset clears the count to zero; the RAM content is left as it is.
// A stalled receiver holds the result register, and the engine waits once it has a
// beat to load; the queue keeps taking commands until it fills.
// ----------------------------------------------------------------------------
module positional_ordered_list_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_op,
    input  wire logic signed [31:0]          s_value,
    input  wire logic [pol_pkg::POS_W-1:0]   s_position,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [2:0]                       m_status,
    output logic signed [31:0]               m_data,
    output logic [pol_pkg::WHERE_W-1:0]      m_where,
    output logic                             m_last
);
    logic          q_valid, q_pop;
    pol_pkg::cmd_t q_cmd;

    pol_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_value(s_value), .s_position(s_position),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    pol_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_data(m_data), .m_where(m_where), .m_last(m_last)
    );
endmodule
`default_nettype wire

// ===== design/pol_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pol_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/pol_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pol_front: command intake and queue
// Accepts input beats and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pol_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_op,
    input  wire logic signed [31:0]        s_value,
    input  wire logic [pol_pkg::POS_W-1:0] s_position,
    output logic                           q_valid,
    input  wire logic                      q_pop,
    output pol_pkg::cmd_t                  q_cmd
);
    localparam int QAW = $clog2(pol_pkg::QDEPTH);

    pol_pkg::cmd_t   q_mem_reg [pol_pkg::QDEPTH];
    logic [QAW-1:0]  wp_reg, rp_reg;
    logic [QAW:0]    cnt_reg;
    logic            push;

    assign s_ready = (cnt_reg != pol_pkg::QDEPTH[QAW:0]);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = q_mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (q_pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wp_reg] <= '{op: pol_pkg::op_t'(s_op), value: s_value,
                                   position: s_position};
        end
    end
endmodule
`default_nettype wire

// ===== design/pol_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pol_back: list engine
// Runs one command at a time against the entry RAM: shifts, scans, readout.
// ----------------------------------------------------------------------------
module pol_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    output logic                             q_pop,
    input  wire pol_pkg::cmd_t               q_cmd,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [2:0]                       m_status,
    output logic signed [31:0]               m_data,
    output logic [pol_pkg::WHERE_W-1:0]      m_where,
    output logic                             m_last
);
    localparam int AW = pol_pkg::AW;
    localparam int CW = pol_pkg::CW;

    pol_pkg::bk_state_t state_reg, state_next;
    pol_pkg::cmd_t      cmd_reg, cmd_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;   // walk index
    logic [CW-1:0]      slot_reg, slot_next;
    logic [31:0]        hold_reg, hold_next; // deleted value
    // single result waiting for the output register
    logic [2:0]         res_st_reg, res_st_next;
    logic [31:0]        res_dat_reg, res_dat_next;
    logic [CW-1:0]      res_wh_reg, res_wh_next;
    logic               ov_reg, ov_next;
    logic [2:0]         ost_reg, ost_next;
    logic [31:0]        odat_reg, odat_next;
    logic [CW-1:0]      owh_reg, owh_next;
    logic               olst_reg, olst_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [31:0]        wdata, rdata;

    logic               cpos_big;
    logic [CW-1:0]      cpos;
    logic [CW-1:0]      del_slot;

    pol_ram #(.WIDTH(32), .DEPTH(pol_pkg::DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign m_valid  = ov_reg;
    assign m_status = ost_reg;
    assign m_data   = odat_reg;
    assign m_where  = pol_pkg::WHERE_W'(owh_reg);
    assign m_last   = olst_reg;

    // position clipped to DEPTH+1; anything above DEPTH is past the end
    assign cpos_big = (cmd_reg.position > pol_pkg::POS_W'(pol_pkg::DEPTH));
    assign cpos     = cpos_big ? CW'(pol_pkg::DEPTH + 1) :
                      CW'(cmd_reg.position);
    assign del_slot = (cpos <= CW'(1)) ? '0 : cpos - 1'b1;

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        hold_next    = hold_reg;
        res_st_next  = res_st_reg;
        res_dat_next = res_dat_reg;
        res_wh_next  = res_wh_reg;
        ov_next      = ov_reg;
        ost_next     = ost_reg;
        odat_next    = odat_reg;
        owh_next     = owh_reg;
        olst_next    = olst_reg;
        q_pop        = 1'b0;
        we           = 1'b0;
        waddr        = idx_reg[AW-1:0];
        wdata        = rdata;
        raddr        = idx_reg[AW-1:0];

        if (ov_reg && m_ready) begin
            ov_next = 1'b0;
        end

        case (state_reg)
            pol_pkg::BK_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = pol_pkg::BK_DECIDE;
                end
            end
            pol_pkg::BK_DECIDE: begin
                idx_next = '0;
                case (cmd_reg.op)
                    pol_pkg::OP_INSERT: begin
                        if (count_reg == CW'(pol_pkg::DEPTH)) begin
                            res_st_next  = pol_pkg::ST_FULL;
                            res_dat_next = cmd_reg.value;
                            res_wh_next  = '0;
                            state_next   = pol_pkg::BK_EMIT;
                        end else begin
                            if (count_reg == '0 || cpos <= CW'(1)) begin
                                slot_next = '0;
                            end else if (cpos - 1'b1 > count_reg) begin
                                slot_next = count_reg;
                            end else begin
                                slot_next = cpos - 1'b1;
                            end
                            // walk down from the top, moving each entry up one
                            idx_next   = count_reg;
                            state_next = pol_pkg::BK_SHIFT_RD;
                        end
                    end
                    pol_pkg::OP_DELETE: begin
                        if (count_reg == '0) begin
                            res_st_next  = pol_pkg::ST_EMPTY;
                            res_dat_next = '0;
                            res_wh_next  = '0;
                            state_next   = pol_pkg::BK_EMIT;
                        end else if (cpos > count_reg) begin
                            res_st_next  = pol_pkg::ST_BOUNDS;
                            res_dat_next = '0;
                            res_wh_next  = '0;
                            state_next   = pol_pkg::BK_EMIT;
                        end else begin
                            // fetch the removed value first
                            slot_next  = del_slot;
                            idx_next   = del_slot;
                            raddr      = del_slot[AW-1:0];
                            state_next = pol_pkg::BK_HOLD;
                        end
                    end
                    pol_pkg::OP_DUMP: begin
                        if (count_reg == '0) begin
                            res_st_next  = pol_pkg::ST_EMPTY;
                            res_dat_next = '0;
                            res_wh_next  = '0;
                            state_next   = pol_pkg::BK_EMIT;
                        end else begin
                            state_next = pol_pkg::BK_SCAN;
                        end
                    end
                    default: begin
                        if (count_reg == '0) begin
                            res_st_next  = pol_pkg::ST_EMPTY;
                            res_dat_next = cmd_reg.value;
                            res_wh_next  = '0;
                            state_next   = pol_pkg::BK_EMIT;
                        end else begin
                            state_next = pol_pkg::BK_SCAN;
                        end
                    end
                endcase
            end
            pol_pkg::BK_HOLD: begin
                hold_next  = rdata;
                state_next = pol_pkg::BK_SHIFT_RD;
            end
            pol_pkg::BK_SHIFT_RD: begin
                // issue the read for this step of the shift, or finish at the end of the walk
                if (cmd_reg.op == pol_pkg::OP_INSERT) begin
                    if (idx_reg == slot_reg) begin
                        we           = 1'b1;
                        waddr        = slot_reg[AW-1:0];
                        wdata        = cmd_reg.value;
                        count_next   = count_reg + 1'b1;
                        res_st_next  = pol_pkg::ST_OK;
                        res_dat_next = cmd_reg.value;
                        res_wh_next  = slot_reg + 1'b1;
                        state_next   = pol_pkg::BK_EMIT;
                    end else begin
                        raddr      = AW'(idx_reg - 1'b1);
                        state_next = pol_pkg::BK_SHIFT_WR;
                    end
                end else begin
                    if (idx_reg == count_reg - 1'b1) begin
                        count_next   = count_reg - 1'b1;
                        res_st_next  = pol_pkg::ST_OK;
                        res_dat_next = hold_reg;
                        res_wh_next  = slot_reg + 1'b1;
                        state_next   = pol_pkg::BK_EMIT;
                    end else begin
                        raddr      = AW'(idx_reg + 1'b1);
                        state_next = pol_pkg::BK_SHIFT_WR;
                    end
                end
            end
            pol_pkg::BK_SHIFT_WR: begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                state_next = pol_pkg::BK_SHIFT_RD;
                if (cmd_reg.op == pol_pkg::OP_INSERT) begin
                    idx_next = idx_reg - 1'b1;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pol_pkg::BK_SCAN: begin
                if (!ov_reg || m_ready) begin
                    raddr      = idx_reg[AW-1:0];
                    state_next = pol_pkg::BK_SCAN_CHK;
                end
            end
            pol_pkg::BK_SCAN_CHK: begin
                if (cmd_reg.op == pol_pkg::OP_DUMP) begin
                    ov_next    = 1'b1;
                    ost_next   = pol_pkg::ST_OK;
                    odat_next  = rdata;
                    owh_next   = idx_reg + 1'b1;
                    olst_next  = (idx_reg + 1'b1 == count_reg);
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_reg + 1'b1 == count_reg) ?
                                 pol_pkg::BK_IDLE : pol_pkg::BK_SCAN;
                end else if (rdata == cmd_reg.value) begin
                    res_st_next  = pol_pkg::ST_OK;
                    res_dat_next = cmd_reg.value;
                    res_wh_next  = idx_reg + 1'b1;
                    state_next   = pol_pkg::BK_EMIT;
                end else if (idx_reg + 1'b1 == count_reg) begin
                    res_st_next  = pol_pkg::ST_NOTFOUND;
                    res_dat_next = cmd_reg.value;
                    res_wh_next  = '0;
                    state_next   = pol_pkg::BK_EMIT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    raddr      = AW'(idx_reg + 1'b1);
                    state_next = pol_pkg::BK_SCAN_CHK;
                end
            end
            pol_pkg::BK_EMIT: begin
                // load the output register only once it is free
                if (!ov_reg || m_ready) begin
                    ov_next    = 1'b1;
                    ost_next   = res_st_reg;
                    odat_next  = res_dat_reg;
                    owh_next   = res_wh_reg;
                    olst_next  = 1'b1;
                    state_next = pol_pkg::BK_IDLE;
                end
            end
            default: state_next = pol_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pol_pkg::BK_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        idx_reg     <= idx_next;
        slot_reg    <= slot_next;
        hold_reg    <= hold_next;
        res_st_reg  <= res_st_next;
        res_dat_reg <= res_dat_next;
        res_wh_reg  <= res_wh_next;
        ost_reg     <= ost_next;
        odat_reg    <= odat_next;
        owh_reg     <= owh_next;
        olst_reg    <= olst_next;
    end
endmodule
`default_nettype wire

// ===== test/positional_ordered_list_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list_top_tb: self-checking bench for the ordered list
// Drives insert, delete, readout and search beats with random gaps on both
// channels, predicts every result beat from a local copy of the list and
// compares each returned beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module positional_ordered_list_top_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        pol_pkg::op_t     op;
        logic [31:0]      value;
        logic [7:0]       position;
        bit               typed;
        pol_pkg::status_t exp_status;
        logic [31:0]      exp_data;
        logic [6:0]       exp_where;
    } stim_row_t;

    typedef struct {
        pol_pkg::status_t status;
        logic [31:0]      data;
        logic [6:0]       where_pos;
        logic             last;
    } list_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic signed [31:0] s_value;
    logic [7:0]  s_position;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic signed [31:0] m_data;
    logic [6:0]  m_where;
    logic        m_last;

    logic [31:0] list_vals [$];
    list_beat_t  pending_beats [$];
    int          mismatch_count;
    int          idle_cycles;
    bit          hold_off;

    positional_ordered_list_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_value(s_value), .s_position(s_position),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_data(m_data), .m_where(m_where), .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic int short_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // Apply one command to the local list and queue the beats it yields.
    task automatic predict_list_op(input pol_pkg::op_t op, input logic [31:0] val,
                                   input logic [7:0] pos);
        int n;
        int slot;
        list_beat_t b;
        n = list_vals.size();
        b.last = 1'b1;
        case (op)
            pol_pkg::OP_INSERT: begin
                if (n >= pol_pkg::DEPTH) begin
                    b.status = pol_pkg::ST_FULL; b.data = val; b.where_pos = '0;
                end else begin
                    if (n == 0 || pos <= 1) slot = 0;
                    else if (pos - 1 > n) slot = n;
                    else slot = pos - 1;
                    list_vals.insert(slot, val);
                    b.status = pol_pkg::ST_OK; b.data = val; b.where_pos = 7'(slot + 1);
                end
                pending_beats.push_back(b);
            end
            pol_pkg::OP_DELETE: begin
                b.data = '0; b.where_pos = '0;
                if (n == 0) b.status = pol_pkg::ST_EMPTY;
                else if (pos > n) b.status = pol_pkg::ST_BOUNDS;
                else begin
                    slot = (pos <= 1) ? 0 : pos - 1;
                    b.status = pol_pkg::ST_OK; b.data = list_vals[slot];
                    b.where_pos = 7'(slot + 1);
                    list_vals.delete(slot);
                end
                pending_beats.push_back(b);
            end
            pol_pkg::OP_DUMP: begin
                if (n == 0) begin
                    b.status = pol_pkg::ST_EMPTY; b.data = '0; b.where_pos = '0;
                    pending_beats.push_back(b);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        b.status = pol_pkg::ST_OK; b.data = list_vals[i];
                        b.where_pos = 7'(i + 1); b.last = (i == n - 1);
                        pending_beats.push_back(b);
                    end
                end
            end
            default: begin
                b.data = val; b.where_pos = '0;
                b.status = (n == 0) ? pol_pkg::ST_EMPTY : pol_pkg::ST_NOTFOUND;
                for (int i = 0; i < n; i++) begin
                    if (list_vals[i] == val && b.status != pol_pkg::ST_OK) begin
                        b.status = pol_pkg::ST_OK; b.where_pos = 7'(i + 1);
                    end
                end
                pending_beats.push_back(b);
            end
        endcase
    endtask

    task automatic send_beat(input pol_pkg::op_t op, input logic [31:0] val,
                             input logic [7:0] pos);
        int gap;
        gap = short_gap();
        repeat (gap) @(negedge aclk);
        s_valid = 1'b1; s_op = op; s_value = val; s_position = pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_list_op(op, val, pos);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Check returned beats against the oldest prediction.
    always @(posedge aclk) begin
        list_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat data", m_data, 0);
            end else begin
                e = pending_beats.pop_front();
                if (m_status !== e.status) report_mismatch("status", m_status, e.status);
                if (m_data !== e.data) report_mismatch("data", m_data, e.data);
                if (m_where !== e.where_pos) report_mismatch("where", m_where, e.where_pos);
                if (m_last !== e.last) report_mismatch("last", m_last, e.last);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready = 1'b0;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            gap = short_gap();
            if (gap == 0) m_ready = 1'b1;
            else begin
                m_ready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
                m_ready = 1'b1;
            end
        end
    end

    // Watchdog on cycles with no beat moving.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        stim_row_t rows [$];
        int k;
        pol_pkg::op_t op;
        logic [31:0] v;
        logic [7:0] p;
        mismatch_count = 0; idle_cycles = 0; hold_off = 0;
        aresetn = 1'b0; s_valid = 1'b0;
        s_op = pol_pkg::OP_INSERT; s_value = '0; s_position = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table: typed results where obvious, predictor elsewhere.
        rows.push_back('{pol_pkg::OP_DUMP, 32'h0, 8'd0, 1'b1,
                         pol_pkg::ST_EMPTY, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_DELETE, 32'h0, 8'd1, 1'b1,
                         pol_pkg::ST_EMPTY, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_SEARCH, 32'h1234, 8'd0, 1'b1,
                         pol_pkg::ST_EMPTY, 32'h1234, 7'd0});
        rows.push_back('{pol_pkg::OP_INSERT, 32'h8000_0000, 8'd255, 1'b1,
                         pol_pkg::ST_OK, 32'h8000_0000, 7'd1});
        rows.push_back('{pol_pkg::OP_INSERT, 32'h7FFF_FFFF, 8'd0, 1'b1,
                         pol_pkg::ST_OK, 32'h7FFF_FFFF, 7'd1});
        rows.push_back('{pol_pkg::OP_INSERT, 32'hFFFF_FFFF, 8'd255, 1'b0,
                         pol_pkg::ST_OK, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_INSERT, 32'h0, 8'd2, 1'b0,
                         pol_pkg::ST_OK, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_INSERT, 32'h5555_AAAA, 8'd1, 1'b0,
                         pol_pkg::ST_OK, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_DUMP, 32'h0, 8'd0, 1'b0,
                         pol_pkg::ST_OK, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_SEARCH, 32'hFFFF_FFFF, 8'd0, 1'b0,
                         pol_pkg::ST_OK, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_SEARCH, 32'h0BAD_0BAD, 8'd0, 1'b1,
                         pol_pkg::ST_NOTFOUND, 32'h0BAD_0BAD, 7'd0});
        rows.push_back('{pol_pkg::OP_DELETE, 32'h0, 8'd255, 1'b1,
                         pol_pkg::ST_BOUNDS, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_DELETE, 32'h0, 8'd6, 1'b1,
                         pol_pkg::ST_BOUNDS, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_DELETE, 32'h0, 8'd5, 1'b0,
                         pol_pkg::ST_OK, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_DELETE, 32'h0, 8'd0, 1'b0,
                         pol_pkg::ST_OK, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_DELETE, 32'h0, 8'd2, 1'b0,
                         pol_pkg::ST_OK, 32'h0, 7'd0});
        rows.push_back('{pol_pkg::OP_DUMP, 32'h0, 8'd0, 1'b0,
                         pol_pkg::ST_OK, 32'h0, 7'd0});
        foreach (rows[i]) begin
            send_beat(rows[i].op, rows[i].value, rows[i].position);
            // typed rows each yield a single beat
            if (rows[i].typed) begin
                pending_beats[pending_beats.size() - 1].status = rows[i].exp_status;
                pending_beats[pending_beats.size() - 1].data = rows[i].exp_data;
                pending_beats[pending_beats.size() - 1].where_pos = rows[i].exp_where;
            end
        end

        // Fill to capacity, overflow once, read out, with a long receiver hold-off.
        hold_off = 1'b1;
        while (list_vals.size() < pol_pkg::DEPTH)
            send_beat(pol_pkg::OP_INSERT, $urandom, 8'($urandom));
        send_beat(pol_pkg::OP_INSERT, 32'hDEAD_BEEF, 8'd3);
        send_beat(pol_pkg::OP_DUMP, '0, '0);
        send_beat(pol_pkg::OP_SEARCH, list_vals[pol_pkg::DEPTH - 1], '0);
        send_beat(pol_pkg::OP_DELETE, '0, 8'd64);
        send_beat(pol_pkg::OP_DELETE, '0, 8'd65);

        // Random part: small, random or (for search) stored values; positions mostly near the list size.
        for (int n = 0; n < 120; n++) begin
            k = $urandom_range(0, 99);
            if (k < 40) op = pol_pkg::OP_INSERT;
            else if (k < 75) op = pol_pkg::OP_DELETE;
            else if (k < 85) op = pol_pkg::OP_DUMP;
            else op = pol_pkg::OP_SEARCH;
            v = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
            if (op == pol_pkg::OP_SEARCH && list_vals.size() > 0 && $urandom_range(0, 1))
                v = list_vals[$urandom_range(0, list_vals.size() - 1)];
            if ($urandom_range(0, 4) == 0) p = 8'($urandom);
            else p = 8'($urandom_range(0, list_vals.size() + 2));
            send_beat(op, v, p);
        end

        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
design/pol_pkg.sv
design/pol_ram.sv
design/pol_front.sv
design/pol_back.sv
design/positional_ordered_list_top.sv
test/positional_ordered_list_top_tb.sv
